/* hw/rtl/ngs_pkg.sv */
package ngs_pkg;

	localparam int COORD_W = 20;
	localparam int PIX_W   = 12;
	localparam int FRAC_W  = COORD_W - PIX_W;
	localparam int SLOT_W  = 8;
	localparam int CNT_W   = 9;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int DIST_W  = SQ_W + 2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} gen_pt_t;

	// slot number traveling alongside a table read
	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] idx;
	} ngs_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} ngs_state_t;

endpackage

/* hw/rtl/ngs_if.sv */
interface ngs_req_if;
	import ngs_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [SLOT_W-1:0]  gen_slot;
	logic [COORD_W-1:0] gen_x;
	logic [COORD_W-1:0] gen_y;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;

	modport source (output valid, req_type, gen_slot, gen_x, gen_y, pixel_x, pixel_y,
		input ready);
	modport sink (input valid, req_type, gen_slot, gen_x, gen_y, pixel_x, pixel_y,
		output ready);
endinterface

interface ngs_rsp_if;
	import ngs_pkg::*;

	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] nearest_index;

	modport source (output valid, nearest_index, input ready);
	modport sink (input valid, nearest_index, output ready);
endinterface

interface ngs_cfg_if;
	import ngs_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] site_count;

	modport source (output valid, site_count, input ready);
	modport sink (input valid, site_count, output ready);
endinterface

/* hw/rtl/ngs_gen_mem.sv */
module ngs_gen_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  ngs_pkg::gen_pt_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ngs_pkg::gen_pt_t rd_data
);
	import ngs_pkg::*;

	gen_pt_t mem [DEPTH];
	gen_pt_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/ngs_dist.sv */
module ngs_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ngs_pkg::ngs_tag_t           tag_s1,
	input  ngs_pkg::gen_pt_t            gen_s1,
	input  logic [ngs_pkg::COORD_W-1:0] px,
	input  logic [ngs_pkg::COORD_W-1:0] py,
	output ngs_pkg::ngs_tag_t           tag_s3,
	output logic [ngs_pkg::DIST_W-1:0]  dist_s3,
	output logic                        busy
);
	import ngs_pkg::*;

	ngs_tag_t           tag_s2, tag_s3_q;
	logic [COORD_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]    sqx_s3, sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3_q <= '0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3_q <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= (gen_s1.x >= px) ? gen_s1.x - px : px - gen_s1.x;
		dy_s2  <= (gen_s1.y >= py) ? gen_s1.y - py : py - gen_s1.y;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	assign tag_s3  = tag_s3_q;
	assign dist_s3 = DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
	assign busy    = tag_s2.vld | tag_s3_q.vld;

endmodule

/* hw/rtl/nearest_generator_search.sv */
// channel | dir | handshake     | word
// --------+-----+---------------+----------------------------------------------
// req     | in  | valid / ready | req_type, gen_slot, gen_x, gen_y, pixel_x/y
// rsp     | out | valid / ready | nearest_index
// cfg     | in  | valid / ready | site_count (always ready)
//
// A load writes the table as it is taken. A query reaches rsp after a scan of N table
// entries (none when N is zero), where N is site_count clamped to MAX_GENERATORS: the
// scan reads one table entry per cycle from the single read port, then drains a
// three-stage pipe. One query is in flight at a time; rsp has its own register, so
// the next word is taken while a result waits. arst_n clears control state; the
// table holds garbage until loaded.
module nearest_generator_search #(
	parameter int MAX_GENERATORS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	ngs_req_if.sink      req,
	ngs_rsp_if.source    rsp,
	ngs_cfg_if.sink      cfg
);
	import ngs_pkg::*;

	localparam int AW = (MAX_GENERATORS > 1) ? $clog2(MAX_GENERATORS) : 1;

	ngs_state_t         state_q, state_d;
	logic [CNT_W-1:0]   count_q, lim_q, lim_new, scan_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [CNT_W-1:0]   best_idx_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic               rsp_vld_q;
	logic [SLOT_W-1:0]  rsp_idx_q;
	ngs_tag_t           tag_s1, tag_s3;
	gen_pt_t            gen_s1, wr_pt;
	logic [DIST_W-1:0]  dist_s3;
	logic               busy;
	logic               req_rdy, issue, start, finish, wr_en;

	assign lim_new = (32'(count_q) > MAX_GENERATORS) ? CNT_W'(MAX_GENERATORS) : count_q;

	always_comb begin
		state_d = state_q;
		req_rdy = 1'b0;
		issue   = 1'b0;
		start   = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_rdy = 1'b1;
				if (req.valid && req.req_type == REQ_QUERY) begin
					start   = 1'b1;
					state_d = (lim_new == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (scan_q == lim_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!tag_s1.vld && !busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_vld_q || rsp.ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign wr_en = req.valid && req_rdy && req.req_type == REQ_LOAD &&
		(32'(req.gen_slot) < MAX_GENERATORS);
	assign wr_pt.x = req.gen_x;
	assign wr_pt.y = req.gen_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rsp_vld_q  <= 1'b0;
			tag_s1.vld <= 1'b0;
			tag_s1.idx <= '0;
		end else begin
			state_q    <= state_d;
			tag_s1.vld <= issue;
			tag_s1.idx <= scan_q;
			if (cfg.valid) begin
				count_q <= cfg.site_count;
			end
			if (finish) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lim_q      <= lim_new;
			scan_q     <= '0;
			px_q       <= {req.pixel_x, FRAC_W'(0)};
			py_q       <= {req.pixel_y, FRAC_W'(0)};
			best_idx_q <= '0;
		end else if (issue) begin
			scan_q <= scan_q + CNT_W'(1);
		end
		// first slot always wins; later ones need a strictly smaller distance
		if (tag_s3.vld && (tag_s3.idx == '0 || dist_s3 < best_dist_q)) begin
			best_idx_q  <= tag_s3.idx;
			best_dist_q <= dist_s3;
		end
		if (finish) begin
			rsp_idx_q <= best_idx_q[SLOT_W-1:0];
		end
	end

	ngs_gen_mem #(
		.DEPTH (MAX_GENERATORS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(req.gen_slot)),
		.wr_data (wr_pt),
		.rd_en   (issue),
		.rd_addr (AW'(scan_q)),
		.rd_data (gen_s1)
	);

	ngs_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.gen_s1  (gen_s1),
		.px      (px_q),
		.py      (py_q),
		.tag_s3  (tag_s3),
		.dist_s3 (dist_s3),
		.busy    (busy)
	);

	assign req.ready         = req_rdy;
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = rsp_vld_q;
	assign rsp.nearest_index = rsp_idx_q;

endmodule

/* tb/sv/nearest_generator_search_tb.sv */
`timescale 1ns / 1ps

module nearest_generator_search_tb;
	import ngs_pkg::*;

	localparam int N_SLOTS    = 256;
	localparam int N_WORDS    = 1650;
	localparam int N_DIR_ROWS = 24;
	localparam int MAX_SHOWN  = 10;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_LOAD,
		ROW_QUERY
	} row_kind_t;

	// a: slot or count, b/c: generator x/y or pixel x/y
	typedef struct packed {
		row_kind_t          kind;
		logic [CNT_W-1:0]   a;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] c;
		logic               typed;
		logic [SLOT_W-1:0]  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ngs_req_if req_ch ();
	ngs_rsp_if rsp_ch ();
	ngs_cfg_if cfg_ch ();

	nearest_generator_search #(
		.MAX_GENERATORS(N_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow of the generator table and the count register
	logic [COORD_W-1:0] site_x [N_SLOTS];
	logic [COORD_W-1:0] site_y [N_SLOTS];
	bit                 site_loaded [N_SLOTS];
	logic [CNT_W-1:0]   search_count;

	logic [SLOT_W-1:0] nearest_q [$];
	int                mismatch_cnt = 0;
	int                words_sent = 0;
	bit                steady = 1'b0;

	dir_row_t dir_rows [N_DIR_ROWS] = '{
		'{ROW_QUERY, 9'd0,   20'd0,       20'd0,       1'b1, 8'd0},  // count 0 after reset
		'{ROW_QUERY, 9'd0,   20'd4095,    20'd4095,    1'b1, 8'd0},
		'{ROW_LOAD,  9'd0,   20'h00000,   20'h00000,   1'b0, 8'd0},
		'{ROW_LOAD,  9'd1,   20'hFFFFF,   20'hFFFFF,   1'b0, 8'd0},
		'{ROW_LOAD,  9'd2,   20'hFFFFF,   20'h00000,   1'b0, 8'd0},
		'{ROW_LOAD,  9'd3,   20'h00000,   20'hFFFFF,   1'b0, 8'd0},
		'{ROW_CFG,   9'd1,   20'd0,       20'd0,       1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd4095,    20'd4095,    1'b1, 8'd0},
		'{ROW_CFG,   9'd4,   20'd0,       20'd0,       1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd0,       20'd0,       1'b1, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd4095,    20'd4095,    1'b1, 8'd1},
		'{ROW_QUERY, 9'd0,   20'd4095,    20'd0,       1'b1, 8'd2},
		'{ROW_QUERY, 9'd0,   20'd0,       20'd4095,    1'b1, 8'd3},
		'{ROW_LOAD,  9'd4,   20'h00000,   20'h00000,   1'b0, 8'd0},
		'{ROW_CFG,   9'd5,   20'd0,       20'd0,       1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd0,       20'd0,       1'b1, 8'd0},  // tie, lower slot wins
		'{ROW_LOAD,  9'd0,   20'h80000,   20'h80000,   1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd0,       20'd0,       1'b1, 8'd4},
		'{ROW_QUERY, 9'd0,   20'd2048,    20'd2048,    1'b1, 8'd0},
		'{ROW_LOAD,  9'd5,   20'h7FF80,   20'h80080,   1'b0, 8'd0},
		'{ROW_LOAD,  9'd255, 20'h03039,   20'h0D431,   1'b0, 8'd0},
		'{ROW_CFG,   9'd6,   20'd0,       20'd0,       1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd2048,    20'd2049,    1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   20'd1000,    20'd3000,    1'b0, 8'd0}
	};

	function automatic logic [SLOT_W-1:0] nearest_slot(input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] py);
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [DIST_W-1:0]  sq_sum;
		logic [DIST_W-1:0]  best;
		logic [SLOT_W-1:0]  best_slot;
		int                 span;
		qx = {px, {FRAC_W{1'b0}}};
		qy = {py, {FRAC_W{1'b0}}};
		span = (search_count > N_SLOTS) ? N_SLOTS : int'(search_count);
		best = '0;
		best_slot = '0;
		for (int i = 0; i < span; i++) begin
			dx = (site_x[i] >= qx) ? site_x[i] - qx : qx - site_x[i];
			dy = (site_y[i] >= qy) ? site_y[i] - qy : qy - site_y[i];
			sq_sum = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
			if (i == 0 || sq_sum < best) begin
				best = sq_sum;
				best_slot = SLOT_W'(i);
			end
		end
		return best_slot;
	endfunction

	// mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// pixel a couple of columns off a generator coordinate
	function automatic logic [PIX_W-1:0] near_pix(input logic [COORD_W-1:0] c);
		int p;
		p = int'(c[COORD_W-1:FRAC_W]) + $urandom_range(0, 4) - 2;
		if (p < 0)
			p = 0;
		if (p > 4095)
			p = 4095;
		return PIX_W'(p);
	endfunction

	task automatic push_req(input logic kind, input logic [SLOT_W-1:0] slot,
			input logic [COORD_W-1:0] gx, input logic [COORD_W-1:0] gy,
			input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
			input logic typed, input logic [SLOT_W-1:0] want);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.gen_slot <= slot;
		req_ch.gen_x    <= gx;
		req_ch.gen_y    <= gy;
		req_ch.pixel_x  <= px;
		req_ch.pixel_y  <= py;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		if (kind == REQ_LOAD) begin
			site_x[slot] = gx;
			site_y[slot] = gy;
			site_loaded[slot] = 1'b1;
		end else begin
			nearest_q.push_back(typed ? want : nearest_slot(px, py));
		end
		words_sent++;
	endtask

	task automatic set_count(input logic [CNT_W-1:0] cnt);
		req_ch.valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		// loads still settling into the table
		repeat (4) @(posedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.site_count <= cnt;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		search_count = cnt;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input logic [SLOT_W-1:0] want,
			input logic [SLOT_W-1:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_SHOWN)
			$display("%0t: %s nearest_index expected %0d got %0d", $realtime, what, want, got);
	endtask

	task automatic random_load(input int eff);
		logic [SLOT_W-1:0]  slot;
		logic [COORD_W-1:0] gx;
		logic [COORD_W-1:0] gy;
		int                 src;
		int                 r;
		if (eff > 0 && $urandom_range(0, 9) < 7)
			slot = SLOT_W'($urandom_range(0, eff - 1));
		else
			slot = SLOT_W'($urandom_range(0, N_SLOTS - 1));
		src = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
		r = $urandom_range(0, 3);
		if (r == 0 && site_loaded[src]) begin
			// duplicate site makes a tie
			gx = site_x[src];
			gy = site_y[src];
		end else if (r == 1) begin
			gx = COORD_W'($urandom_range(0, 20'h03FFF));
			gy = COORD_W'($urandom_range(0, 20'h03FFF));
		end else begin
			gx = COORD_W'($urandom);
			gy = COORD_W'($urandom);
		end
		push_req(REQ_LOAD, slot, gx, gy, PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
	endtask

	task automatic random_query(input int eff);
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
		int               src;
		int               r;
		src = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			px = PIX_W'($urandom);
			py = PIX_W'($urandom);
		end else if (r < 8 && site_loaded[src]) begin
			px = near_pix(site_x[src]);
			py = near_pix(site_y[src]);
		end else begin
			px = $urandom_range(0, 1) ? '1 : '0;
			py = $urandom_range(0, 1) ? '1 : '0;
		end
		push_req(REQ_QUERY, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			px, py, 1'b0, '0);
	endtask

	initial begin
		int               r;
		int               eff;
		int               n;
		logic [CNT_W-1:0] cnt;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_LOAD;
		req_ch.gen_slot   <= '0;
		req_ch.gen_x      <= '0;
		req_ch.gen_y      <= '0;
		req_ch.pixel_x    <= '0;
		req_ch.pixel_y    <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.site_count <= '0;
		search_count = '0;
		for (int i = 0; i < N_SLOTS; i++) begin
			site_x[i] = '0;
			site_y[i] = '0;
			site_loaded[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: begin
					set_count(dir_rows[i].a);
				end
				ROW_LOAD: begin
					push_req(REQ_LOAD, dir_rows[i].a[SLOT_W-1:0], dir_rows[i].b, dir_rows[i].c,
						PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
				end
				default: begin
					push_req(REQ_QUERY, SLOT_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom), dir_rows[i].b[PIX_W-1:0], dir_rows[i].c[PIX_W-1:0],
						dir_rows[i].typed, dir_rows[i].want);
				end
			endcase
		end

		while (words_sent < N_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				cnt = '0;
			else if (r < 8)
				cnt = CNT_W'(N_SLOTS);
			else if (r < 11)
				cnt = CNT_W'($urandom_range(N_SLOTS + 1, 511));  // clamps to full table
			else if (r < 20)
				cnt = CNT_W'(1);
			else if (r < 70)
				cnt = CNT_W'($urandom_range(2, 16));
			else
				cnt = CNT_W'($urandom_range(17, 64));
			eff = (cnt > N_SLOTS) ? N_SLOTS : int'(cnt);

			// every slot the search will touch must hold a site first
			steady = 1'b0;
			for (int s = 0; s < eff; s++) begin
				if (!site_loaded[s])
					push_req(REQ_LOAD, SLOT_W'(s), COORD_W'($urandom), COORD_W'($urandom),
						PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
			end
			set_count(cnt);

			steady = ($urandom_range(0, 3) == 0);
			n = (eff > 64) ? $urandom_range(3, 8) : $urandom_range(10, 40);
			repeat (n) begin
				if ($urandom_range(0, 99) < 55)
					random_query(eff);
				else
					random_load(eff);
			end
		end

		req_ch.valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("nearest_generator_search verification clean");
		else
			$display("nearest_generator_search verification failed");
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall_left;
		bit calm;
		stall_left = 0;
		calm = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			if ($urandom_range(0, 499) == 0)
				calm = !calm;
		end
	end

	initial begin
		logic [SLOT_W-1:0] want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (nearest_q.size() == 0) begin
					flag_mismatch("unexpected word,", '0, rsp_ch.nearest_index);
				end else begin
					want = nearest_q.pop_front();
					if (rsp_ch.nearest_index !== want)
						flag_mismatch("mismatch,", want, rsp_ch.nearest_index);
				end
			end
		end
	end

	initial begin
		#(30_000_000);
		$display("nearest_generator_search verification failed");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ngs_pkg.sv
hw/rtl/ngs_if.sv
hw/rtl/ngs_gen_mem.sv
hw/rtl/ngs_dist.sv
hw/rtl/nearest_generator_search.sv
tb/sv/nearest_generator_search_tb.sv
